// ===== sv/crg_pkg.sv =====
// Shared constants and helpers for the crossbar round-robin grant core.
// No dependencies; imported by crossbar_round_robin_grant_core.
package crg_pkg;

    localparam int PORTS = 8;               // active ports, 2..8
    localparam int ROW_W = 8;               // request bits per output row
    localparam int IDX_W = 3;               // bits of one granted input index
    localparam int REQ_W = ROW_W * ROW_W;   // request word width
    localparam int GV_W  = ROW_W;           // grant mask width
    localparam int GI_W  = ROW_W * IDX_W;   // packed grant index width
    localparam int SEL_W = IDX_W + 1;       // search position, holds up to 2*PORTS-1

    typedef logic [REQ_W-1:0] t_req;

    // Request bits that address an existing input/output pair.
    function automatic t_req port_mask();
        t_req m;
        m = '0;
        for (int o = 0; o < PORTS; o++) begin
            for (int i = 0; i < PORTS; i++) begin
                m[o*ROW_W + i] = 1'b1;
            end
        end
        return m;
    endfunction

endpackage

// ===== sv/crossbar_round_robin_grant_core.sv =====
// Single-pass round-robin grant arbiter for an 8x8 crossbar.
// Depends on crg_pkg for port counts, field widths and the port mask.
//
// Usage:
//   Input channel (i_valid / o_stall): one word per timeslot, carrying
//   i_new_requests, bit output*8+input set when that input wants that
//   output. Bits of ports at or beyond PORTS are dropped.
//   Output channel (o_valid / i_stall): one word per input word, carrying
//   o_grant_valid (one bit per output) and o_grant_inputs (3-bit granted
//   input per output, output 0 lowest; zero where nothing was granted).
// Pipeline: an accepted input word is held in the input register; its result
//   word is then presented from the result register.
// Throughput: one word per cycle while the receiver does not stall; the grant
//   chain walks the outputs in order in one combinational pass between the
//   input register and the result register, so both stages advance together.
// Stall: when the receiver stalls, the result register holds; one further
//   input word is still taken into the input register, after which o_stall
//   rises until the result is taken. No word is lost or repeated.
// Reset (i_rst_n low, synchronous): pending requests clear, all pointers go
//   to "none" (search from input 0), both stages empty.
module crossbar_round_robin_grant_core
    import crg_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [REQ_W-1:0]  i_new_requests,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [GV_W-1:0]   o_grant_valid,
    output logic [GI_W-1:0]   o_grant_inputs
);

    // Input stage.
    logic             r_in_valid;
    t_req             r_in_req;

    // Arbiter state: pending request matrix and per-output pointers.
    t_req             r_req;
    t_req             n_req;
    logic [PORTS-1:0] r_ptr_valid;
    logic [IDX_W-1:0] r_ptr_idx [PORTS];
    logic [IDX_W-1:0] n_ptr_idx [PORTS];

    // Result stage.
    logic             r_out_valid;
    logic [GV_W-1:0]  r_gv;
    logic [GI_W-1:0]  r_gi;

    // Grant pass outputs.
    t_req             c_clear;
    logic [GV_W-1:0]  c_taken;
    logic [GV_W-1:0]  c_gv;
    logic [GI_W-1:0]  c_gi;

    logic out_free;
    logic fire;
    logic in_take;

    assign out_free = !r_out_valid || !i_stall;
    assign fire     = r_in_valid && out_free;       // grant pass commits
    assign o_stall  = r_in_valid && !out_free;
    assign in_take  = i_valid && !o_stall;

    // Grant chain: outputs in order, each searches from pointer+1 with wrap,
    // skipping inputs already taken by a lower output in this slot.
    always_comb begin
        t_req             req;
        logic [SEL_W-1:0] start;
        logic [SEL_W-1:0] sum;
        logic [SEL_W-1:0] cand;
        logic             found;
        logic [IDX_W-1:0] pick;
        req     = r_req | (r_in_req & port_mask());
        c_clear = '0;
        c_taken = '0;
        c_gv    = '0;
        c_gi    = '0;
        start   = '0;
        sum     = '0;
        cand    = '0;
        found   = 1'b0;
        pick    = '0;
        for (int o = 0; o < PORTS; o++) begin
            start = r_ptr_valid[o] ? ({1'b0, r_ptr_idx[o]} + SEL_W'(1)) : '0;
            found = 1'b0;
            pick  = '0;
            for (int k = 0; k < PORTS; k++) begin
                sum  = start + SEL_W'(k);
                cand = (sum >= SEL_W'(PORTS)) ? (sum - SEL_W'(PORTS)) : sum;
                if (!found && req[o*ROW_W + int'(cand[IDX_W-1:0])]
                        && !c_taken[cand[IDX_W-1:0]]) begin
                    found = 1'b1;
                    pick  = cand[IDX_W-1:0];
                end
            end
            n_ptr_idx[o] = pick;
            if (found) begin
                c_taken[pick]                 = 1'b1;
                c_gv[o]                       = 1'b1;
                c_gi[o*IDX_W +: IDX_W]        = pick;
                c_clear[o*ROW_W + int'(pick)] = 1'b1;
            end
        end
        n_req = req & ~c_clear;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_req       <= '0;
            r_ptr_valid <= '0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
                r_req       <= n_req;
                r_ptr_valid <= c_gv[PORTS-1:0];
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers, no reset.
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_req <= i_new_requests;
        end
        if (fire) begin
            r_gv <= c_gv;
            r_gi <= c_gi;
            for (int o = 0; o < PORTS; o++) begin
                r_ptr_idx[o] <= n_ptr_idx[o];
            end
        end
    end

    assign o_valid        = r_out_valid;
    assign o_grant_valid  = r_gv;
    assign o_grant_inputs = r_gi;

    // Each grant uses a distinct input.
    a_distinct_inputs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |-> ($countones(c_taken) == $countones(c_gv)))
        else $error("two outputs granted the same input");

    // Granted requests are gone after the slot commits.
    a_grants_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> ((r_req & $past(c_clear)) == '0))
        else $error("granted request bit still pending");

    // Pointer valid flags track the grant mask of the last committed slot.
    a_ptr_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> (r_ptr_valid == o_grant_valid[PORTS-1:0]))
        else $error("pointer flags disagree with grant mask");

    // A result appears only from a committed slot.
    a_out_from_fire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($rose(r_out_valid)) |-> $past(fire))
        else $error("result presented without a grant pass");

endmodule
